// ----- src/awdm_pkg.sv -----
// ----------------------------------------------------------------------------
// awdm_pkg: awning drive mode controller shared definitions
// Mode codes, lamp bit positions, default timing values and the structs
// that carry one tick and the controller state.
// ----------------------------------------------------------------------------
package awdm_pkg;

	// default blink timing, in ticks
	localparam int unsigned BLINK_PERIOD_TICKS = 20;
	localparam int unsigned WRAP_TICKS         = 100;

	// blink tick counter runs modulo 128
	localparam int unsigned TICK_W = 7;

	// mode codes
	localparam logic [1:0] MODE_OFF     = 2'd0;
	localparam logic [1:0] MODE_MANUAL  = 2'd1;
	localparam logic [1:0] MODE_AUTO    = 2'd2;
	localparam logic [1:0] MODE_RETRACT = 2'd3;

	// lamp and drive latch bit positions
	localparam int unsigned LAMP_W       = 5;
	localparam int unsigned LAMP_POWER   = 0;
	localparam int unsigned LAMP_AUTO    = 1;
	localparam int unsigned LAMP_MANUAL  = 2;
	localparam int unsigned LAMP_EXTEND  = 3;
	localparam int unsigned LAMP_RETRACT = 4;

	// one 10 ms tick of switch and button levels
	typedef struct packed {
		logic power_switch;
		logic sun_sensor;
		logic auto_switch;
		logic retracted_limit;
		logic extended_limit;
		logic retract_button;
		logic extend_button;
	} awdm_tick_t;

	// controller state, prev_buttons bit 0 retract, bit 1 extend
	typedef struct packed {
		logic [1:0]        mode;
		logic              extend_request;
		logic              blink_enable;
		logic              off_flag;
		logic [1:0]        prev_buttons;
		logic [TICK_W-1:0] blink_ticks;
		logic [LAMP_W-1:0] lamp;
	} awdm_state_t;

endpackage

// ----- src/awdm_tick_if.sv -----
// ----------------------------------------------------------------------------
// awdm_tick_if: tick request channel
// Valid/ready channel carrying the switch and button levels of one tick.
// ----------------------------------------------------------------------------
interface awdm_tick_if;
	logic valid;
	logic ready;
	logic power_switch;
	logic sun_sensor;
	logic auto_switch;
	logic retracted_limit;
	logic extended_limit;
	logic retract_button;
	logic extend_button;

	modport source (
		output valid, power_switch, sun_sensor, auto_switch, retracted_limit,
		       extended_limit, retract_button, extend_button,
		input  ready
	);

	modport sink (
		input  valid, power_switch, sun_sensor, auto_switch, retracted_limit,
		       extended_limit, retract_button, extend_button,
		output ready
	);
endinterface

// ----- src/awdm_result_if.sv -----
// ----------------------------------------------------------------------------
// awdm_result_if: result request channel
// Valid/ready channel carrying lamp, drive and mode outputs of one tick.
// ----------------------------------------------------------------------------
interface awdm_result_if;
	logic       valid;
	logic       ready;
	logic       power_lamp;
	logic       auto_lamp;
	logic       manual_lamp;
	logic       drive_extend;
	logic       drive_retract;
	logic [1:0] mode;

	modport source (
		output valid, power_lamp, auto_lamp, manual_lamp, drive_extend,
		       drive_retract, mode,
		input  ready
	);

	modport sink (
		input  valid, power_lamp, auto_lamp, manual_lamp, drive_extend,
		       drive_retract, mode,
		output ready
	);
endinterface

// ----- src/awdm_step.sv -----
// ----------------------------------------------------------------------------
// awdm_step: next-state logic for one tick
// Button edge detect, mode step, drive/lamp latch update and blink timing.
// Purely combinational; the caller registers the returned state.
// ----------------------------------------------------------------------------
module awdm_step #(
	parameter int unsigned BlinkPeriod = awdm_pkg::BLINK_PERIOD_TICKS,
	parameter int unsigned WrapTicks   = awdm_pkg::WRAP_TICKS,
	localparam int unsigned PhW        = (BlinkPeriod > 1) ? $clog2(BlinkPeriod) : 1
) (
	input  awdm_pkg::awdm_tick_t  tick_in,
	input  awdm_pkg::awdm_state_t cur,
	input  logic [PhW-1:0]        phase,
	output awdm_pkg::awdm_state_t nxt,
	output logic [PhW-1:0]        phase_nxt
);

	localparam logic [awdm_pkg::TICK_W-1:0] WrapVal  = awdm_pkg::TICK_W'(WrapTicks);
	localparam logic [awdm_pkg::TICK_W-1:0] TickMax  = '1;
	localparam logic [PhW-1:0]              HalfVal  = PhW'(BlinkPeriod / 2);
	localparam logic [PhW-1:0]              PhaseTop = PhW'(BlinkPeriod - 1);

	logic                         rise_retract;
	logic                         rise_extend;
	logic                         at_limit;
	logic [awdm_pkg::TICK_W-1:0]  ticks_c;
	logic [PhW-1:0]               phase_c;

	assign rise_retract = tick_in.retract_button & ~cur.prev_buttons[0];
	assign rise_extend  = tick_in.extend_button  & ~cur.prev_buttons[1];
	assign at_limit     = tick_in.retracted_limit | tick_in.extended_limit;

	always_comb begin
		nxt = cur;
		nxt.prev_buttons = {tick_in.extend_button, tick_in.retract_button};

		// mode step
		unique case (cur.mode)
			awdm_pkg::MODE_OFF: begin
				nxt.off_flag = 1'b1;
				if (tick_in.power_switch && tick_in.retracted_limit) begin
					nxt.mode = tick_in.auto_switch ? awdm_pkg::MODE_AUTO
					                               : awdm_pkg::MODE_MANUAL;
					nxt.off_flag = 1'b0;
					nxt.lamp[awdm_pkg::LAMP_POWER] = 1'b1;
				end
			end
			awdm_pkg::MODE_MANUAL: begin
				nxt.blink_enable = 1'b1;
				if (at_limit) begin
					if (rise_retract) nxt.extend_request = 1'b0;
					if (rise_extend)  nxt.extend_request = 1'b1;
					if (tick_in.auto_switch) begin
						nxt.mode = awdm_pkg::MODE_AUTO;
						nxt.blink_enable = 1'b0;
					end
				end
				if (!tick_in.power_switch) begin
					nxt.mode = awdm_pkg::MODE_RETRACT;
					nxt.blink_enable = 1'b0;
				end
			end
			awdm_pkg::MODE_AUTO: begin
				nxt.lamp[awdm_pkg::LAMP_AUTO] = 1'b1;
				if (at_limit) begin
					nxt.extend_request = tick_in.sun_sensor;
					if (!tick_in.auto_switch) begin
						nxt.mode = awdm_pkg::MODE_MANUAL;
						nxt.lamp[awdm_pkg::LAMP_AUTO] = 1'b0;
					end
				end
				if (!tick_in.power_switch) begin
					nxt.mode = awdm_pkg::MODE_RETRACT;
					nxt.lamp[awdm_pkg::LAMP_AUTO] = 1'b0;
				end
			end
			awdm_pkg::MODE_RETRACT: begin
				nxt.extend_request = 1'b0;
				if (tick_in.retracted_limit) nxt.mode = awdm_pkg::MODE_OFF;
			end
		endcase

		// drive outputs, all dark while off
		if (nxt.off_flag) begin
			nxt.lamp = '0;
		end else begin
			nxt.lamp[awdm_pkg::LAMP_EXTEND]  = nxt.extend_request & ~tick_in.extended_limit;
			nxt.lamp[awdm_pkg::LAMP_RETRACT] = ~(nxt.extend_request | tick_in.retracted_limit);
		end

		// blink timing; phase tracks blink_ticks modulo the blink period
		if (nxt.blink_enable) begin
			if (cur.blink_ticks > WrapVal) begin
				ticks_c = '0;
				phase_c = '0;
			end else begin
				ticks_c = cur.blink_ticks;
				phase_c = phase;
			end
			nxt.lamp[awdm_pkg::LAMP_MANUAL] = (phase_c > HalfVal);
		end else begin
			ticks_c = '0;
			phase_c = '0;
			nxt.lamp[awdm_pkg::LAMP_MANUAL] = 1'b0;
		end
		nxt.blink_ticks = ticks_c + 1'b1;
		if (ticks_c == TickMax || phase_c == PhaseTop) phase_nxt = '0;
		else phase_nxt = phase_c + 1'b1;
	end

endmodule

// ----- src/awning_drive_mode_controller.sv -----
// ----------------------------------------------------------------------------
// awning_drive_mode_controller: awning drive mode controller top level
// Registers each tick request, steps the mode controller and holds the
// lamp/drive result in an output register until it is taken.
// ----------------------------------------------------------------------------
//  channel | modport | request carries
//  --------+---------+------------------------------------------------------
//  tick    | sink    | power, sun, auto, both limits, both button levels
//  result  | source  | power/auto/manual lamps, extend/retract drive, mode
//
//  One tick per cycle sustained while results are taken; a taken tick goes
//  through the input register, then the result register holding the new state.
//  The state step is one pass of awdm_step between those two registers.
//  arst_n clears the controller state and both valid flags.
//  A stalled result holds; the input register still takes one more tick.
// ----------------------------------------------------------------------------
module awning_drive_mode_controller #(
	parameter int unsigned BlinkPeriod = awdm_pkg::BLINK_PERIOD_TICKS,
	parameter int unsigned WrapTicks   = awdm_pkg::WRAP_TICKS
) (
	input logic           clk,
	input logic           arst_n,
	awdm_tick_if.sink     tick,
	awdm_result_if.source result
);

	localparam int unsigned PhW = (BlinkPeriod > 1) ? $clog2(BlinkPeriod) : 1;

	logic                  valid_s1;
	awdm_pkg::awdm_tick_t  tick_s1;
	awdm_pkg::awdm_state_t state_q;
	awdm_pkg::awdm_state_t state_nxt;
	logic [PhW-1:0]        phase_q;
	logic [PhW-1:0]        phase_nxt;
	logic                  out_valid_q;
	logic                  advance;

	assign advance    = valid_s1 & (~out_valid_q | result.ready);
	assign tick.ready = ~valid_s1 | advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			tick_s1 <= '{power_switch:    tick.power_switch,
			             sun_sensor:      tick.sun_sensor,
			             auto_switch:     tick.auto_switch,
			             retracted_limit: tick.retracted_limit,
			             extended_limit:  tick.extended_limit,
			             retract_button:  tick.retract_button,
			             extend_button:   tick.extend_button};
		end
	end

	// next-state logic
	awdm_step #(
		.BlinkPeriod (BlinkPeriod),
		.WrapTicks   (WrapTicks)
	) u_step (
		.tick_in   (tick_s1),
		.cur       (state_q),
		.phase     (phase_q),
		.nxt       (state_nxt),
		.phase_nxt (phase_nxt)
	);

	// controller state, also the result payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{mode: awdm_pkg::MODE_OFF, default: '0};
			phase_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
			phase_q <= phase_nxt;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.power_lamp    = state_q.lamp[awdm_pkg::LAMP_POWER];
	assign result.auto_lamp     = state_q.lamp[awdm_pkg::LAMP_AUTO];
	assign result.manual_lamp   = state_q.lamp[awdm_pkg::LAMP_MANUAL];
	assign result.drive_extend  = state_q.lamp[awdm_pkg::LAMP_EXTEND];
	assign result.drive_retract = state_q.lamp[awdm_pkg::LAMP_RETRACT];
	assign result.mode          = state_q.mode;

`ifndef ASSERT_OFF
	// motor never driven both ways
	a_drive_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(state_q.lamp[awdm_pkg::LAMP_EXTEND] && state_q.lamp[awdm_pkg::LAMP_RETRACT]))
		else $error("extend and retract driven together");

	// everything dark while the off flag is set
	a_off_dark: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.off_flag |-> (state_q.lamp == '0))
		else $error("lamp or drive lit while off");

	// manual lamp only lit while blinking
	a_blink_lamp: assert property (@(posedge clk) disable iff (!arst_n)
		!state_q.blink_enable |-> !state_q.lamp[awdm_pkg::LAMP_MANUAL])
		else $error("manual lamp lit with blinking disabled");

	// blink phase stays below the period
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= PhW'(BlinkPeriod - 1))
		else $error("blink phase out of range");

	// a held tick is not dropped by the input register
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(tick_s1)))
		else $error("input register lost a tick");
`endif

endmodule

// ----- tb/tb_awning_drive_mode_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_awning_drive_mode_controller: self-checking bench for the awning drive
// A directed run through power up, both buttons, automatic tracking, power
// off retraction and the limit contacts, then about a thousand ticks of
// slowly wandering switch levels with some noise. Every tick is predicted
// on acceptance and each result request is compared field by field.
// ----------------------------------------------------------------------------
module tb_awning_drive_mode_controller;

	localparam int unsigned RANDOM_TICKS = 1000;
	localparam int unsigned CYCLE_LIMIT  = 300000;
	localparam int unsigned HOLD_CYCLES  = 200;
	localparam int unsigned SETTLE       = 8;

	// one result request as seen on the result channel
	typedef struct packed {
		logic       power_lamp;
		logic       auto_lamp;
		logic       manual_lamp;
		logic       drive_extend;
		logic       drive_retract;
		logic [1:0] mode;
	} drive_result_t;

	// ------------------------------------------------------------------------
	// Lamp and drive predictor with its queue of expected results
	// ------------------------------------------------------------------------
	class drive_board;
		awdm_pkg::awdm_state_t ctl;
		drive_result_t         expected_results[$];
		int unsigned           mismatches;

		function new();
			ctl = '0;
			ctl.mode = awdm_pkg::MODE_OFF;
			mismatches = 0;
		endfunction

		function int unsigned outstanding();
			return expected_results.size();
		endfunction

		// step the controller by one accepted tick and queue its outputs
		function void note_tick(awdm_pkg::awdm_tick_t t);
			logic [1:0]    btn;
			logic [1:0]    rise;
			logic          at_limit;
			drive_result_t r;
			btn = {t.extend_button, t.retract_button};
			rise = btn & ~ctl.prev_buttons;
			at_limit = t.retracted_limit | t.extended_limit;
			ctl.prev_buttons = btn;

			case (ctl.mode)
				awdm_pkg::MODE_OFF: begin
					ctl.off_flag = 1'b1;
					if (t.power_switch && t.retracted_limit) begin
						ctl.mode = t.auto_switch ? awdm_pkg::MODE_AUTO
						                         : awdm_pkg::MODE_MANUAL;
						ctl.off_flag = 1'b0;
						ctl.lamp[awdm_pkg::LAMP_POWER] = 1'b1;
					end
				end
				awdm_pkg::MODE_MANUAL: begin
					ctl.blink_enable = 1'b1;
					if (at_limit) begin
						if (rise[0])
							ctl.extend_request = 1'b0;
						if (rise[1])
							ctl.extend_request = 1'b1;
						if (t.auto_switch) begin
							ctl.mode = awdm_pkg::MODE_AUTO;
							ctl.blink_enable = 1'b0;
						end
					end
					if (!t.power_switch) begin
						ctl.mode = awdm_pkg::MODE_RETRACT;
						ctl.blink_enable = 1'b0;
					end
				end
				awdm_pkg::MODE_AUTO: begin
					ctl.lamp[awdm_pkg::LAMP_AUTO] = 1'b1;
					if (at_limit) begin
						ctl.extend_request = t.sun_sensor;
						if (!t.auto_switch) begin
							ctl.mode = awdm_pkg::MODE_MANUAL;
							ctl.lamp[awdm_pkg::LAMP_AUTO] = 1'b0;
						end
					end
					if (!t.power_switch) begin
						ctl.mode = awdm_pkg::MODE_RETRACT;
						ctl.lamp[awdm_pkg::LAMP_AUTO] = 1'b0;
					end
				end
				default: begin
					ctl.extend_request = 1'b0;
					if (t.retracted_limit)
						ctl.mode = awdm_pkg::MODE_OFF;
				end
			endcase

			// drive bits, all dark while off
			if (ctl.off_flag) begin
				ctl.lamp = '0;
			end else begin
				ctl.lamp[awdm_pkg::LAMP_EXTEND]  = ctl.extend_request & ~t.extended_limit;
				ctl.lamp[awdm_pkg::LAMP_RETRACT] = ~(ctl.extend_request | t.retracted_limit);
			end

			// manual lamp blink
			if (ctl.blink_enable) begin
				if (ctl.blink_ticks > awdm_pkg::WRAP_TICKS)
					ctl.blink_ticks = '0;
				ctl.lamp[awdm_pkg::LAMP_MANUAL] =
					(int'(ctl.blink_ticks) % awdm_pkg::BLINK_PERIOD_TICKS) >
					(awdm_pkg::BLINK_PERIOD_TICKS / 2);
			end else begin
				ctl.lamp[awdm_pkg::LAMP_MANUAL] = 1'b0;
				ctl.blink_ticks = '0;
			end
			ctl.blink_ticks = ctl.blink_ticks + 1'b1;

			r.power_lamp    = ctl.lamp[awdm_pkg::LAMP_POWER];
			r.auto_lamp     = ctl.lamp[awdm_pkg::LAMP_AUTO];
			r.manual_lamp   = ctl.lamp[awdm_pkg::LAMP_MANUAL];
			r.drive_extend  = ctl.lamp[awdm_pkg::LAMP_EXTEND];
			r.drive_retract = ctl.lamp[awdm_pkg::LAMP_RETRACT];
			r.mode          = ctl.mode;
			expected_results.push_back(r);
		endfunction

		// compare a taken result with the oldest expectation
		function void check_result(drive_result_t got);
			drive_result_t exp_r;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with none expected: %p", $realtime, got);
				return;
			end
			exp_r = expected_results.pop_front();
			if (got.power_lamp !== exp_r.power_lamp || got.auto_lamp !== exp_r.auto_lamp ||
			    got.manual_lamp !== exp_r.manual_lamp ||
			    got.drive_extend !== exp_r.drive_extend ||
			    got.drive_retract !== exp_r.drive_retract || got.mode !== exp_r.mode) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: mismatch expected %p got %p", $realtime, exp_r, got);
			end
		endfunction
	endclass

	logic          clk;
	logic          arst_n;
	awdm_tick_if   tick_if ();
	awdm_result_if res_if ();
	drive_board    board;

	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned phase;
	int unsigned cycle_count;
	logic        hold;

	awning_drive_mode_controller dut (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick_if),
		.result (res_if)
	);

	// 10 ns clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// result side: random stalls plus one long hold-off
	initial begin
		res_if.ready <= 1'b0;
		forever begin
			@(negedge clk);
			res_if.ready <= !hold && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// long hold-off at the start of the last phase, so the block backs up
	initial begin
		hold <= 1'b0;
		wait (phase == 3);
		@(negedge clk);
		hold <= 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		hold <= 1'b0;
	end

	// check every taken result request
	always @(posedge clk) begin : take_result
		drive_result_t seen;
		if (arst_n && res_if.valid && res_if.ready) begin
			seen.power_lamp    = res_if.power_lamp;
			seen.auto_lamp     = res_if.auto_lamp;
			seen.manual_lamp   = res_if.manual_lamp;
			seen.drive_extend  = res_if.drive_extend;
			seen.drive_retract = res_if.drive_retract;
			seen.mode          = res_if.mode;
			board.check_result(seen);
		end
	end

	// offer one tick request, called at a falling edge, returns at one
	task automatic send_tick(input awdm_pkg::awdm_tick_t t);
		while ($urandom_range(99) < send_idle_pct) begin
			tick_if.valid <= 1'b0;
			@(negedge clk);
		end
		tick_if.valid           <= 1'b1;
		tick_if.power_switch    <= t.power_switch;
		tick_if.sun_sensor      <= t.sun_sensor;
		tick_if.auto_switch     <= t.auto_switch;
		tick_if.retracted_limit <= t.retracted_limit;
		tick_if.extended_limit  <= t.extended_limit;
		tick_if.retract_button  <= t.retract_button;
		tick_if.extend_button   <= t.extend_button;
		@(posedge clk);
		while (!tick_if.ready)
			@(posedge clk);
		board.note_tick(t);
		@(negedge clk);
	endtask

	// switch levels that drift slowly, with the odd noise tick between them
	task automatic send_wandering(input int unsigned count, inout awdm_pkg::awdm_tick_t lvl);
		logic [6:0] noise;
		for (int unsigned i = 0; i < count; i++) begin
			if ($urandom_range(9) == 0) begin
				noise = $urandom_range(127);
				send_tick(awdm_pkg::awdm_tick_t'(noise));
			end else begin
				if ($urandom_range(99) == 0)
					lvl.power_switch = ~lvl.power_switch;
				if ($urandom_range(9) == 0)
					lvl.sun_sensor = ~lvl.sun_sensor;
				if ($urandom_range(79) == 0)
					lvl.auto_switch = ~lvl.auto_switch;
				if ($urandom_range(7) == 0)
					lvl.retracted_limit = ~lvl.retracted_limit;
				if ($urandom_range(7) == 0)
					lvl.extended_limit = ~lvl.extended_limit;
				if ($urandom_range(3) == 0)
					lvl.retract_button = ~lvl.retract_button;
				if ($urandom_range(3) == 0)
					lvl.extend_button = ~lvl.extend_button;
				send_tick(lvl);
			end
		end
	endtask

	// fields: power, sun, auto, retracted limit, extended limit, retract, extend
	awdm_pkg::awdm_tick_t directed[$] = '{
		7'b0000000,  // idle while off
		7'b1000000,  // power on away from the retracted limit stays off
		7'b1001000,  // power on at retracted limit, manual
		7'b1001001,  // extend press at a limit
		7'b1000001,  // travelling out
		7'b1000100,  // extend cut at the extended limit
		7'b1000110,  // retract press
		7'b1001111,  // both limits with an extend press
		7'b1110100,  // automatic selected at a limit
		7'b1011000,  // no sun, retract
		7'b1110100,  // sun, extend request, cut by limit
		7'b1000100,  // back to manual
		7'b0000100,  // power off from manual
		7'b0000000,  // retracting
		7'b0001000,  // retracted, off
		7'b0000000,  // off, all dark
		7'b1011000,  // straight into automatic
		7'b0000000,  // power off from automatic
		7'b0001100,  // both limits while retracting
		7'b1111111,  // everything high from off
		7'b1111111,  // everything high in automatic
		7'b1101100   // sun, both limits
	};

	initial begin : stimulus
		awdm_pkg::awdm_tick_t lvl;
		board = new();
		phase = 1;
		send_idle_pct = 6;
		recv_stall_pct = 66;
		arst_n <= 1'b0;
		tick_if.valid <= 1'b0;
		tick_if.power_switch <= 1'b0;
		tick_if.sun_sensor <= 1'b0;
		tick_if.auto_switch <= 1'b0;
		tick_if.retracted_limit <= 1'b0;
		tick_if.extended_limit <= 1'b0;
		tick_if.retract_button <= 1'b0;
		tick_if.extend_button <= 1'b0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed[i])
			send_tick(directed[i]);

		// powered, manual, parked at the retracted limit
		lvl = 7'b1001000;
		send_wandering(RANDOM_TICKS / 3, lvl);

		phase = 2;
		send_idle_pct = 66;
		recv_stall_pct = 6;
		send_wandering(RANDOM_TICKS / 3, lvl);

		phase = 3;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_wandering(RANDOM_TICKS - 2 * (RANDOM_TICKS / 3), lvl);
		tick_if.valid <= 1'b0;

		// drain
		while (board.outstanding() != 0 || hold)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		if (board.mismatches == 0 && board.outstanding() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
